>>> rtl/core/baro_sensor_compensation_top_defines.svh
// Assertion macros shared by the barometric compensation RTL.
// No dependencies; included by the files that carry assertions.
`ifndef BARO_SENSOR_COMPENSATION_TOP_DEFINES_SVH
`define BARO_SENSOR_COMPENSATION_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define BSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define BSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/bsc_pkg.sv
// Constants for the barometric compensation pipeline.
// No dependencies; used by the top level through scoped names.
`default_nettype none

package bsc_pkg;

    typedef enum logic [2:0] {
        REG_AC1_AC2 = 3'd0,
        REG_AC3_AC4 = 3'd1,
        REG_AC5_AC6 = 3'd2,
        REG_B1_B2   = 3'd3,
        REG_MC_MD   = 3'd4
    } cfg_sel_t;

    localparam int TEMP_NUM_W = 27;
    localparam int TEMP_DEN_W = 18;
    localparam int PRES_NUM_W = 32;
    localparam int PRES_DEN_W = 32;

    localparam logic [31:0] CAL0_RESET = 32'd26804152;
    localparam logic [31:0] CAL1_RESET = 32'd3352395749;
    localparam logic [31:0] CAL2_RESET = 32'd2146785905;
    localparam logic [31:0] CAL3_RESET = 32'd405667844;
    localparam logic [31:0] CAL4_RESET = 32'd3724086068;

    localparam logic signed [27:0] B6_OFFSET  = 28'sd4000;
    localparam logic [31:0]        X3_BIAS    = 32'd32768;
    localparam logic [15:0]        B7_SCALE   = 16'd50000;
    localparam logic [11:0]        P_COEF_SQ  = 12'd3038;
    localparam logic [12:0]        P_COEF_LIN = 13'd7357;
    localparam logic signed [47:0] P_COEF_OFS = 48'sd3791;

    localparam logic signed [15:0] TEMP_MAX  = 16'sh7fff;
    localparam logic signed [15:0] TEMP_MIN  = 16'sh8000;
    localparam logic [17:0]        PRES_MAX  = 18'h3ffff;

endpackage

`default_nettype wire

>>> rtl/core/bsc_delay.sv
// Stall-aware delay line that carries a valid bit and a sideband word.
// No dependencies; runs beside each pipelined divider.
`default_nettype none

module bsc_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    output logic [WIDTH-1:0]      out_data
);

    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] data_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg[0] <= in_data;
            for (int i = 1; i < DEPTH; i++)
            begin
                data_reg[i] <= data_reg[i-1];
            end
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign out_data  = data_reg[DEPTH-1];

endmodule

`default_nettype wire

>>> rtl/core/bsc_div_pipe.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// No dependencies.
`default_nettype none

module bsc_div_pipe #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 32
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0]      quo
);

    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];
    logic [NUM_W-1:0] quo_reg [NUM_W];

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] num_in;
        logic [DEN_W-1:0] den_in;
        logic [NUM_W-1:0] quo_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             take;

        if (i == 0)
        begin : g_first
            assign rem_in = '0;
            assign num_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign num_in = num_reg[i-1];
            assign den_in = den_reg[i-1];
            assign quo_in = quo_reg[i-1];
        end

        assign trial = {rem_in, num_in[NUM_W-1]};
        assign diff  = trial - {1'b0, den_in};
        assign take  = (trial >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                num_reg[i] <= {num_in[NUM_W-2:0], 1'b0};
                den_reg[i] <= den_in;
                quo_reg[i] <= {quo_in[NUM_W-2:0], take};
            end
        end
    end

    assign quo = quo_reg[NUM_W-1];

endmodule

`default_nettype wire

>>> rtl/core/baro_sensor_compensation_top.sv
// Barometric compensation pipeline: calibration registers, stages and dividers.
// Depends on bsc_pkg, bsc_div_pipe, bsc_delay and the assertion macro header.
//
// One reading pair enters every cycle unless the output stalls; its result passes
// through the two bit-serial divider pipelines (27 and 32 stages) plus 14 other
// register stages, the last of which is the output register. A stall on the output
// freezes the whole pipeline, so the input sees stall in the same cycle.
`default_nettype none
`include "baro_sensor_compensation_top_defines.svh"

module baro_sensor_compensation_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [15:0]        raw_temperature,
    input  wire logic [23:0]        raw_pressure,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      temperature_tenths,
    output logic [17:0]             pressure_pa,
    output logic                    divide_fault,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);

    logic [31:0] cal0_reg, cal1_reg, cal2_reg, cal3_reg, cal4_reg;
    logic        en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal0_reg <= bsc_pkg::CAL0_RESET;
            cal1_reg <= bsc_pkg::CAL1_RESET;
            cal2_reg <= bsc_pkg::CAL2_RESET;
            cal3_reg <= bsc_pkg::CAL3_RESET;
            cal4_reg <= bsc_pkg::CAL4_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bsc_pkg::REG_AC1_AC2: cal0_reg <= cfg_data;
                bsc_pkg::REG_AC3_AC4: cal1_reg <= cfg_data;
                bsc_pkg::REG_AC5_AC6: cal2_reg <= cfg_data;
                bsc_pkg::REG_B1_B2:   cal3_reg <= cfg_data;
                bsc_pkg::REG_MC_MD:   cal4_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [15:0]        ac4, ac5, ac6;

    assign ac1 = $signed(cal0_reg[31:16]);
    assign ac2 = $signed(cal0_reg[15:0]);
    assign ac3 = $signed(cal1_reg[31:16]);
    assign ac4 = cal1_reg[15:0];
    assign ac5 = cal2_reg[31:16];
    assign ac6 = cal2_reg[15:0];
    assign b1  = $signed(cal3_reg[31:16]);
    assign b2  = $signed(cal3_reg[15:0]);
    assign mc  = $signed(cal4_reg[31:16]);
    assign md  = $signed(cal4_reg[15:0]);

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // Stage 0: input capture.
    logic        s0_valid_reg;
    logic [15:0] s0_ut_reg;
    logic [15:0] s0_up_reg;

    // Stage 1: (UT - AC6) * AC5.
    logic               s1_valid_reg;
    logic signed [33:0] s1_prod_reg;
    logic [15:0]        s1_up_reg;
    logic signed [16:0] s1_diff;
    logic signed [16:0] s1_ac5;
    logic signed [33:0] s1_prod_next;

    // Stage 2: X1 and the temperature divisor.
    logic               s2_valid_reg;
    logic signed [17:0] s2_x1_reg;
    logic signed [18:0] s2_den_reg;
    logic [15:0]        s2_up_reg;
    logic signed [17:0] s2_x1_next;
    logic signed [18:0] s2_den_next;

    // Stage 3: magnitudes into the temperature divider.
    logic               s3_valid_reg;
    logic [26:0]        s3_num_reg;
    logic [17:0]        s3_den_reg;
    logic [35:0]        s3_side_reg;
    logic [15:0]        s3_mc_mag;
    logic signed [18:0] s3_den_neg;

    always_comb
    begin
        s1_diff      = $signed({1'b0, s0_ut_reg}) - $signed({1'b0, ac6});
        s1_ac5       = $signed({1'b0, ac5});
        s1_prod_next = s1_diff * s1_ac5;
        s2_x1_next   = s1_prod_reg[32:15];
        s2_den_next  = {s2_x1_next[17], s2_x1_next} + {{3{md[15]}}, md};
        s3_mc_mag    = mc[15] ? 16'(-mc) : 16'(mc);
        s3_den_neg   = -s2_den_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= in_valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_ut_reg   <= raw_temperature;
            s0_up_reg   <= raw_pressure[23:8];
            s1_prod_reg <= s1_prod_next;
            s1_up_reg   <= s0_up_reg;
            s2_x1_reg   <= s2_x1_next;
            s2_den_reg  <= s2_den_next;
            s2_up_reg   <= s1_up_reg;
            s3_num_reg  <= {s3_mc_mag, 11'b0};
            s3_den_reg  <= s2_den_reg[18] ? s3_den_neg[17:0] : s2_den_reg[17:0];
            s3_side_reg <= {s2_x1_reg, mc[15] ^ s2_den_reg[18],
                            (s2_den_reg == '0), s2_up_reg};
        end
    end

    logic [26:0] tdiv_quo;
    logic        tdl_valid;
    logic [35:0] tdl_side;

    bsc_div_pipe #(
        .NUM_W (bsc_pkg::TEMP_NUM_W),
        .DEN_W (bsc_pkg::TEMP_DEN_W)
    ) u_tdiv (
        .clk (clk),
        .en  (en),
        .num (s3_num_reg),
        .den (s3_den_reg),
        .quo (tdiv_quo)
    );

    bsc_delay #(
        .WIDTH (36),
        .DEPTH (bsc_pkg::TEMP_NUM_W)
    ) u_tdelay (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .in_data   (s3_side_reg),
        .out_valid (tdl_valid),
        .out_data  (tdl_side)
    );

    // Stage 4: B5, temperature, B6.
    logic               s4_valid_reg;
    logic signed [15:0] s4_t_reg;
    logic signed [27:0] s4_b6_reg;
    logic               s4_tfault_reg;
    logic [15:0]        s4_up_reg;
    logic signed [17:0] s4_x1;
    logic signed [27:0] s4_x2;
    logic signed [27:0] s4_b5;
    logic signed [27:0] s4_b5r;
    logic signed [23:0] s4_t24;
    logic signed [15:0] s4_t_next;

    always_comb
    begin
        s4_x1  = $signed(tdl_side[35:18]);
        s4_x2  = tdl_side[17] ? -$signed({1'b0, tdiv_quo}) : $signed({1'b0, tdiv_quo});
        s4_b5  = {{10{s4_x1[17]}}, s4_x1} + s4_x2;
        s4_b5r = s4_b5 + 28'sd8;
        s4_t24 = s4_b5r[27:4];
        if (tdl_side[16])
        begin
            s4_t_next = bsc_pkg::TEMP_MAX;
        end
        else if (s4_t24 > 24'sd32767)
        begin
            s4_t_next = bsc_pkg::TEMP_MAX;
        end
        else if (s4_t24 < -24'sd32768)
        begin
            s4_t_next = bsc_pkg::TEMP_MIN;
        end
        else
        begin
            s4_t_next = s4_t24[15:0];
        end
    end

    // Stage 5: B6 squared and the linear B6 products.
    logic               s5_valid_reg;
    logic [53:0]        s5_sq_reg;
    logic signed [43:0] s5_ac2b6_reg;
    logic signed [43:0] s5_ac3b6_reg;
    logic signed [15:0] s5_t_reg;
    logic               s5_tfault_reg;
    logic [15:0]        s5_up_reg;
    logic signed [27:0] s5_b6_neg;
    logic [26:0]        s5_b6_mag;
    logic signed [43:0] s5_ac2;
    logic signed [43:0] s5_ac3;
    logic signed [43:0] s5_b6w;

    // Stage 6: B2 and B1 times (B6 * B6) >> 12.
    logic               s6_valid_reg;
    logic signed [58:0] s6_p1_reg;
    logic signed [58:0] s6_p2_reg;
    logic signed [43:0] s6_ac2b6_reg;
    logic signed [43:0] s6_ac3b6_reg;
    logic signed [15:0] s6_t_reg;
    logic               s6_tfault_reg;
    logic [15:0]        s6_up_reg;
    logic signed [58:0] s6_sq12;
    logic signed [58:0] s6_b1;
    logic signed [58:0] s6_b2;

    // Stage 7: low words of B3 and X3.
    logic               s7_valid_reg;
    logic [31:0]        s7_b3_reg;
    logic [31:0]        s7_x3_reg;
    logic signed [15:0] s7_t_reg;
    logic               s7_tfault_reg;
    logic [15:0]        s7_up_reg;
    logic [33:0]        s7_sum_b3;
    logic [33:0]        s7_sum_x3;

    // Stage 8: B4 product and B7.
    logic               s8_valid_reg;
    logic [47:0]        s8_pb4_reg;
    logic [31:0]        s8_b7_reg;
    logic signed [15:0] s8_t_reg;
    logic               s8_tfault_reg;
    logic [31:0]        s8_u;
    logic [31:0]        s8_d7;

    // Stage 9: pressure divider operands.
    logic               s9_valid_reg;
    logic [31:0]        s9_num_reg;
    logic [31:0]        s9_den_reg;
    logic [18:0]        s9_side_reg;
    logic [31:0]        s9_b4;

    always_comb
    begin
        s5_b6_neg = -s4_b6_reg;
        s5_b6_mag = s4_b6_reg[27] ? s5_b6_neg[26:0] : s4_b6_reg[26:0];
        s5_ac2    = 44'(ac2);
        s5_ac3    = 44'(ac3);
        s5_b6w    = 44'(s4_b6_reg);
        s6_sq12   = $signed({17'b0, s5_sq_reg[53:12]});
        s6_b1     = 59'(b1);
        s6_b2     = 59'(b2);
        s7_sum_b3 = s6_p1_reg[44:11] + {s6_ac2b6_reg[43], s6_ac2b6_reg[43:11]}
                  + {{16{ac1[15]}}, ac1, 2'b00} + 34'd2;
        s7_sum_x3 = {{3{s6_ac3b6_reg[43]}}, s6_ac3b6_reg[43:13]} + s6_p2_reg[49:16]
                  + 34'd2;
        s8_u      = s7_x3_reg + bsc_pkg::X3_BIAS;
        s8_d7     = {16'b0, s7_up_reg} - s7_b3_reg;
        s9_b4     = s8_pb4_reg[46:15];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
            s9_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg <= tdl_valid;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= s7_valid_reg;
            s9_valid_reg <= s8_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_t_reg      <= s4_t_next;
            s4_b6_reg     <= s4_b5 - bsc_pkg::B6_OFFSET;
            s4_tfault_reg <= tdl_side[16];
            s4_up_reg     <= tdl_side[15:0];

            s5_sq_reg     <= 54'(s5_b6_mag) * 54'(s5_b6_mag);
            s5_ac2b6_reg  <= s5_ac2 * s5_b6w;
            s5_ac3b6_reg  <= s5_ac3 * s5_b6w;
            s5_t_reg      <= s4_t_reg;
            s5_tfault_reg <= s4_tfault_reg;
            s5_up_reg     <= s4_up_reg;

            s6_p1_reg     <= s6_b2 * s6_sq12;
            s6_p2_reg     <= s6_b1 * s6_sq12;
            s6_ac2b6_reg  <= s5_ac2b6_reg;
            s6_ac3b6_reg  <= s5_ac3b6_reg;
            s6_t_reg      <= s5_t_reg;
            s6_tfault_reg <= s5_tfault_reg;
            s6_up_reg     <= s5_up_reg;

            s7_b3_reg     <= s7_sum_b3[33:2];
            s7_x3_reg     <= s7_sum_x3[33:2];
            s7_t_reg      <= s6_t_reg;
            s7_tfault_reg <= s6_tfault_reg;
            s7_up_reg     <= s6_up_reg;

            s8_pb4_reg    <= 48'(ac4) * 48'(s8_u);
            s8_b7_reg     <= 32'(s8_d7 * 32'(bsc_pkg::B7_SCALE));
            s8_t_reg      <= s7_t_reg;
            s8_tfault_reg <= s7_tfault_reg;

            s9_num_reg    <= s8_b7_reg[31] ? s8_b7_reg : {s8_b7_reg[30:0], 1'b0};
            s9_den_reg    <= s9_b4;
            s9_side_reg   <= {s8_t_reg, s8_tfault_reg, (s9_b4 == '0), s8_b7_reg[31]};
        end
    end

    logic [31:0] pdiv_quo;
    logic        pdl_valid;
    logic [18:0] pdl_side;

    bsc_div_pipe #(
        .NUM_W (bsc_pkg::PRES_NUM_W),
        .DEN_W (bsc_pkg::PRES_DEN_W)
    ) u_pdiv (
        .clk (clk),
        .en  (en),
        .num (s9_num_reg),
        .den (s9_den_reg),
        .quo (pdiv_quo)
    );

    bsc_delay #(
        .WIDTH (19),
        .DEPTH (bsc_pkg::PRES_NUM_W)
    ) u_pdelay (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s9_valid_reg),
        .in_data   (s9_side_reg),
        .out_valid (pdl_valid),
        .out_data  (pdl_side)
    );

    // Stage 10: quotient scaling. Stages 11 to 13: final pressure correction.
    logic               s10_valid_reg;
    logic [31:0]        s10_pq_reg;
    logic [17:0]        s10_side_reg;
    logic               s11_valid_reg;
    logic [47:0]        s11_sqp_reg;
    logic [44:0]        s11_m2_reg;
    logic [31:0]        s11_pq_reg;
    logic [17:0]        s11_side_reg;
    logic               s12_valid_reg;
    logic [59:0]        s12_x1_reg;
    logic [44:0]        s12_m2_reg;
    logic [31:0]        s12_pq_reg;
    logic [17:0]        s12_side_reg;
    logic               out_valid_reg;
    logic signed [15:0] out_t_reg;
    logic [17:0]        out_p_reg;
    logic               out_fault_reg;

    logic signed [46:0] s13_neg_m2;
    logic signed [47:0] s13_sum;
    logic signed [47:0] s13_p;
    logic [17:0]        s13_p_sat;

    always_comb
    begin
        s13_neg_m2 = -$signed({2'b0, s12_m2_reg});
        s13_sum    = $signed({4'b0, s12_x1_reg[59:16]})
                   + 48'(s13_neg_m2 >>> 16) + bsc_pkg::P_COEF_OFS;
        s13_p      = $signed({16'b0, s12_pq_reg}) + (s13_sum >>> 4);
        if (s13_p < 48'sd0)
        begin
            s13_p_sat = '0;
        end
        else if (s13_p > 48'sd262143)
        begin
            s13_p_sat = bsc_pkg::PRES_MAX;
        end
        else
        begin
            s13_p_sat = s13_p[17:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s10_valid_reg <= 1'b0;
            s11_valid_reg <= 1'b0;
            s12_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s10_valid_reg <= pdl_valid;
            s11_valid_reg <= s10_valid_reg;
            s12_valid_reg <= s11_valid_reg;
            out_valid_reg <= s12_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s10_pq_reg   <= pdl_side[0] ? {pdiv_quo[30:0], 1'b0} : pdiv_quo;
            s10_side_reg <= pdl_side[18:1];

            s11_sqp_reg  <= 48'(s10_pq_reg[31:8]) * 48'(s10_pq_reg[31:8]);
            s11_m2_reg   <= 45'(s10_pq_reg) * 45'(bsc_pkg::P_COEF_LIN);
            s11_pq_reg   <= s10_pq_reg;
            s11_side_reg <= s10_side_reg;

            s12_x1_reg   <= 60'(s11_sqp_reg) * 60'(bsc_pkg::P_COEF_SQ);
            s12_m2_reg   <= s11_m2_reg;
            s12_pq_reg   <= s11_pq_reg;
            s12_side_reg <= s11_side_reg;

            out_t_reg     <= $signed(s12_side_reg[17:2]);
            out_p_reg     <= (s12_side_reg[1] || s12_side_reg[0]) ? bsc_pkg::PRES_MAX
                                                                  : s13_p_sat;
            out_fault_reg <= s12_side_reg[1] || s12_side_reg[0];
        end
    end

    assign out_valid          = out_valid_reg;
    assign temperature_tenths = out_t_reg;
    assign pressure_pa        = out_p_reg;
    assign divide_fault       = out_fault_reg;

    `BSC_ASSERT_NOW(a_fault_saturates, out_valid && divide_fault, pressure_pa == bsc_pkg::PRES_MAX, "divide fault without saturated pressure")
    `BSC_ASSERT_NEXT(a_tail_advance, en, out_valid == $past(s12_valid_reg), "output valid did not follow the last stage")
    `BSC_ASSERT_NOW(a_backpressure, out_valid && out_stall, in_stall, "input taken while the output is blocked")

endmodule

`default_nettype wire

>>> bench/baro_checker.sv
// Checker for the barometric compensation block: watches the calibration port and both
// channels, predicts each compensated reading and compares it with the block's output.
// Depends on bsc_pkg for the calibration reset values.
module baro_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_stall,
    input  wire logic [15:0]       raw_temperature,
    input  wire logic [23:0]       raw_pressure,
    input  wire logic              out_valid,
    input  wire logic              out_stall,
    input  wire logic signed [15:0] temperature_tenths,
    input  wire logic [17:0]       pressure_pa,
    input  wire logic              divide_fault,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [31:0]       cfg_data,
    output int                     mismatches,
    output int                     readings_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] tenths;
        logic [17:0]        pascal;
        logic               fault;
    } reading_t;

    logic [31:0] cal [5];
    reading_t    expected_readings [$];

    function automatic longint hi_s(input logic [31:0] r);
        return longint'($signed(r[31:16]));
    endfunction

    function automatic longint lo_s(input logic [31:0] r);
        return longint'($signed(r[15:0]));
    endfunction

    function automatic reading_t compensate(input logic [15:0] ut_raw, input logic [23:0] up_raw);
        reading_t   r;
        longint     ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut;
        longint     x1, x2, x3, b3, b5, b6, t, p, sq, q8;
        logic [63:0] prod;
        logic [31:0] up, b4, b7, diff, pq, dbl;
        ac1 = hi_s(cal[0]);
        ac2 = lo_s(cal[0]);
        ac3 = hi_s(cal[1]);
        ac4 = longint'({48'd0, cal[1][15:0]});
        ac5 = longint'({48'd0, cal[2][31:16]});
        ac6 = longint'({48'd0, cal[2][15:0]});
        b1  = hi_s(cal[3]);
        b2  = lo_s(cal[3]);
        mc  = hi_s(cal[4]);
        md  = lo_s(cal[4]);
        ut  = longint'({48'd0, ut_raw});
        up  = {16'd0, up_raw[23:8]};
        r.fault = 1'b0;
        x1 = ((ut - ac6) * ac5) >>> 15;
        if (x1 + md == 0)
        begin
            r.tenths = 16'sh7fff;
            r.pascal = 18'h3ffff;
            r.fault  = 1'b1;
            return r;
        end
        x2 = (mc * 2048) / (x1 + md);
        b5 = x1 + x2;
        t  = (b5 + 8) >>> 4;
        if (t > 32767)
            t = 32767;
        if (t < -32768)
            t = -32768;
        r.tenths = t[15:0];

        b6 = b5 - 4000;
        sq = (b6 * b6) >>> 12;
        x1 = (b2 * sq) >>> 11;
        x2 = (ac2 * b6) >>> 11;
        x3 = x1 + x2;
        b3 = (ac1 * 4 + x3 + 2) >>> 2;
        x1 = (ac3 * b6) >>> 13;
        x2 = (b1 * sq) >>> 16;
        x3 = (x1 + x2 + 2) >>> 2;
        x3 = x3 + 32768;
        prod = 64'(ac4) * {32'd0, x3[31:0]};
        b4 = prod[46:15];
        diff = up - b3[31:0];
        b7 = diff * 32'd50000;
        if (b4 == 32'd0)
        begin
            r.pascal = 18'h3ffff;
            r.fault  = 1'b1;
            return r;
        end
        if (b7 < 32'h8000_0000)
        begin
            dbl = b7 << 1;
            pq  = dbl / b4;
        end
        else
        begin
            pq = b7 / b4;
            pq = pq << 1;
        end
        p  = longint'({32'd0, pq});
        q8 = longint'({40'd0, pq[31:8]});
        x1 = ((q8 * q8) * 3038) >>> 16;
        x2 = (-7357 * p) >>> 16;
        p  = p + ((x1 + x2 + 3791) >>> 4);
        if (p < 0)
            p = 0;
        if (p > 262143)
            p = 262143;
        r.pascal = p[17:0];
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    initial mismatches = 0;
    assign readings_pending = expected_readings.size();

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            cal[0] <= bsc_pkg::CAL0_RESET;
            cal[1] <= bsc_pkg::CAL1_RESET;
            cal[2] <= bsc_pkg::CAL2_RESET;
            cal[3] <= bsc_pkg::CAL3_RESET;
            cal[4] <= bsc_pkg::CAL4_RESET;
        end
        else
        begin
            if (cfg_we && cfg_index < 3'd5)
                cal[cfg_index] <= cfg_data;
            if (in_valid && !in_stall)
                expected_readings.push_back(compensate(raw_temperature, raw_pressure));
            if (out_valid && !out_stall)
            begin
                if (expected_readings.size() == 0)
                    report("unexpected beat", {16'd0, temperature_tenths}, 32'd0);
                else
                begin
                    want = expected_readings.pop_front();
                    if (temperature_tenths !== want.tenths)
                        report("temperature_tenths", {16'd0, temperature_tenths},
                               {16'd0, want.tenths});
                    if (pressure_pa !== want.pascal)
                        report("pressure_pa", {14'd0, pressure_pa}, {14'd0, want.pascal});
                    if (divide_fault !== want.fault)
                        report("divide_fault", {31'd0, divide_fault}, {31'd0, want.fault});
                end
            end
        end
    end
endmodule

>>> bench/tb_top.sv
// Top of the barometric compensation bench: clock, reset, calibration writes and
// readings under varying idle patterns. Depends on baro_checker and the block itself.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_DEPTH  = 80;
    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [15:0] raw_temperature = '0;
    logic [23:0] raw_pressure = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [15:0] temperature_tenths;
    logic [17:0] pressure_pa;
    logic divide_fault;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int mismatches;
    int readings_pending;
    int send_idle_pct = 12;
    int recv_idle_pct = 47;
    int cycles = 0;

    baro_sensor_compensation_top dut (.*);
    baro_checker checker_i (.*);

    always #5 clk = ~clk;

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_reading(input logic [15:0] t, input logic [23:0] p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        raw_temperature = t;
        raw_pressure = p;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (readings_pending != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 10) @(negedge clk);
    endtask

    task automatic write_cal(input logic [2:0] idx, input logic [31:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic write_all(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c,
                             input logic [31:0] d, input logic [31:0] e);
        write_cal(bsc_pkg::REG_AC1_AC2, a);
        write_cal(bsc_pkg::REG_AC3_AC4, b);
        write_cal(bsc_pkg::REG_AC5_AC6, c);
        write_cal(bsc_pkg::REG_B1_B2, d);
        write_cal(bsc_pkg::REG_MC_MD, e);
    endtask

    task automatic random_readings(input int count);
        logic [15:0] t;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(3))
                0: t = 16'($urandom_range(20000, 35000));
                1: t = $urandom_range(1) ? 16'hffff : 16'h0000;
                default: t = 16'($urandom);
            endcase
            send_reading(t, 24'($urandom));
        end
    endtask

    task automatic set_idling(input int phase);
        if (phase < 3)
        begin
            send_idle_pct = 12;
            recv_idle_pct = 47;
        end
        else if (phase < 6)
        begin
            send_idle_pct = 47;
            recv_idle_pct = 12;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_reading(16'd27898, 24'd23843 << 8);
        send_reading(16'h0000, 24'h000000);
        send_reading(16'hffff, 24'hffffff);
        send_reading(16'h0000, 24'hffffff);
        send_reading(16'hffff, 24'h000000);
        send_reading(16'h8000, 24'h800000);
        send_reading(16'h7fff, 24'h7fffff);
        send_reading(16'h5555, 24'haaaaaa);
        send_reading(16'haaaa, 24'h555555);
        drain();
        // Zero AC5 and MD make the temperature divisor zero; zero AC4 the pressure one.
        write_cal(bsc_pkg::REG_AC5_AC6, 32'h0000_4271);
        write_cal(bsc_pkg::REG_MC_MD, 32'hd4bd_0000);
        send_reading(16'd27898, 24'd23843 << 8);
        send_reading(16'hffff, 24'hffffff);
        drain();
        write_all(bsc_pkg::CAL0_RESET, 32'hc7d1_0000, bsc_pkg::CAL2_RESET,
                  bsc_pkg::CAL3_RESET, bsc_pkg::CAL4_RESET);
        send_reading(16'd27898, 24'd23843 << 8);
        send_reading(16'h0000, 24'h000000);
        send_reading(16'hffff, 24'hffffff);
        drain();

        for (int phase = 0; phase < 9; phase++)
        begin
            set_idling(phase);
            case (phase % 3)
                0: write_all(bsc_pkg::CAL0_RESET ^ 32'($urandom_range(255)),
                             bsc_pkg::CAL1_RESET ^ 32'($urandom_range(255)),
                             bsc_pkg::CAL2_RESET ^ 32'($urandom_range(255)),
                             bsc_pkg::CAL3_RESET ^ 32'($urandom_range(255)),
                             bsc_pkg::CAL4_RESET ^ 32'($urandom_range(255)));
                1: write_all($urandom, $urandom, $urandom, $urandom, $urandom);
                default:
                    if (phase == 2)
                        write_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
                    else if (phase == 5)
                        write_all(32'hffffffff, 32'hffffffff, 32'hffffffff,
                                  32'hffffffff, 32'hffffffff);
                    else
                        write_all(32'h7fff8000, 32'h8000ffff, 32'hffff0001,
                                  32'h80007fff, 32'h7fff8000);
            endcase
            random_readings(105);
            drain();
            random_readings(105);
            drain();
        end

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
